// ===== rtl/assert_macros.svh =====
// Assertion macros used by the semaphore table top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CST_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("semaphore table assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CST_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("semaphore table assertion failed");

`endif

// ===== rtl/cst_pkg.sv =====
// Types, codes and defaults shared by the counting semaphore table.
package cst_pkg;

	// Fixed transaction field widths.
	localparam int OP_W     = 2;
	localparam int IDX_W    = 8;
	localparam int VAL_W    = 16;
	localparam int STATUS_W = 2;

	// Default table geometry.
	localparam int NUM_SEMAPHORES_DEF = 256;
	localparam int COUNT_WIDTH_DEF    = 16;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_OPEN  = 2'd0;
	localparam logic [OP_W-1:0] OP_CLOSE = 2'd1;
	localparam logic [OP_W-1:0] OP_UP    = 2'd2;
	localparam logic [OP_W-1:0] OP_DOWN  = 2'd3;

	// Status codes.
	localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_REJECTED = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BLOCKED  = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0]  operation;
		logic [IDX_W-1:0] sem_index;
		logic [VAL_W-1:0] initial_value;
	} cst_req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic                wake;
		logic [VAL_W-1:0]    count_after;
	} cst_rsp_t;

	// Outcome of one request from the update logic.
	typedef struct packed {
		logic     wr;
		cst_rsp_t rsp;
	} cst_upd_t;

endpackage

// ===== rtl/counting_semaphore_table.sv =====
// Top level of the counting semaphore table: entry RAM, update stage and result register.
//
//   Channel | Signals                     | Direction | Payload
//   req     | req_valid, req_ready, req   | in        | operation, sem_index, initial_value
//   rsp     | rsp_valid, rsp_ready, rsp   | out       | status, wake, count_after
//
// One transaction per cycle is sustained unless rsp stalls. After accept the entry
// RAM read register feeds the single read-modify-write stage, then the result register.
// Back-to-back requests to one entry use the last written word through a bypass register.
// After reset a clearing pass writes every entry closed while req_ready is held low.
// A stalled rsp holds the update stage and the RAM write.
`include "assert_macros.svh"

module counting_semaphore_table import cst_pkg::*; #(
	parameter int NUM_SEMAPHORES = NUM_SEMAPHORES_DEF,
	parameter int COUNT_WIDTH    = COUNT_WIDTH_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  cst_req_t req,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	output cst_rsp_t rsp
);

	localparam int AW = $clog2(NUM_SEMAPHORES);
	localparam int EW = 2 * COUNT_WIDTH + 1;

	logic          clr_busy_q;
	logic [AW-1:0] clr_addr_q;
	logic          valid_s1;
	cst_req_t      req_s1;
	logic          wr_valid_q;
	logic [AW-1:0] wr_addr_q;
	logic [EW-1:0] wr_data_q;
	logic          rsp_valid_q;
	cst_rsp_t      rsp_q;

	logic          accept;
	logic          adv;
	logic [AW-1:0] addr_s1;
	logic [EW-1:0] rd_data;
	logic [EW-1:0] entry_cur;
	logic [EW-1:0] entry_new;
	cst_upd_t      upd;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [EW-1:0] ram_wdata;

	// Handshake and stage advance.
	assign adv       = valid_s1 && (!rsp_valid_q || rsp_ready);
	assign req_ready = !clr_busy_q && (!valid_s1 || adv);
	assign accept    = req_valid && req_ready;
	assign addr_s1   = AW'(req_s1.sem_index);

	// Use the most recent write when it hit the entry being updated.
	assign entry_cur = (wr_valid_q && (wr_addr_q == addr_s1)) ? wr_data_q : rd_data;

	// Write port: clearing pass first, then updates.
	always_comb begin
		if (clr_busy_q) begin
			ram_we    = 1'b1;
			ram_waddr = clr_addr_q;
			ram_wdata = '0;
		end else begin
			ram_we    = adv && upd.wr;
			ram_waddr = addr_s1;
			ram_wdata = entry_new;
		end
	end

	cst_ram #(
		.WIDTH(EW),
		.DEPTH(NUM_SEMAPHORES)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (accept),
		.raddr(AW'(req.sem_index)),
		.rdata(rd_data)
	);

	cst_engine #(
		.NUM_SEMAPHORES(NUM_SEMAPHORES),
		.COUNT_WIDTH   (COUNT_WIDTH)
	) u_engine (
		.req      (req_s1),
		.entry    (entry_cur),
		.entry_new(entry_new),
		.upd      (upd)
	);

	// Clearing pass after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + AW'(1);
			if (32'(clr_addr_q) == NUM_SEMAPHORES - 1) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// Control of the update stage, bypass and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			wr_valid_q  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (ram_we) begin
				wr_valid_q <= !clr_busy_q;
			end
			if (adv) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req;
		end
		if (ram_we) begin
			wr_addr_q <= ram_waddr;
			wr_data_q <= ram_wdata;
		end
		if (adv) begin
			rsp_q <= upd.rsp;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// No request is taken while the table is being cleared.
	`CST_ASSERT_IMP(a_no_accept_clr, clk, arst_n, clr_busy_q, !req_ready)
	// A stalled update stage leaves the RAM untouched.
	`CST_ASSERT_IMP(a_stall_no_write, clk, arst_n, valid_s1 && !adv && !clr_busy_q, !ram_we)
	// An advancing request always produces a result in the next cycle.
	`CST_ASSERT_NXT(a_adv_result, clk, arst_n, adv, rsp_valid_q)
	// A wake only comes with a completed up that left the count at one.
	`CST_ASSERT_IMP(a_wake_done, clk, arst_n, rsp_valid_q && rsp_q.wake,
		rsp_q.status == ST_DONE && rsp_q.count_after == VAL_W'(1))
	// Status is always one of the defined codes.
	`CST_ASSERT_IMP(a_status_code, clk, arst_n, rsp_valid_q,
		rsp_q.status == ST_DONE || rsp_q.status == ST_REJECTED || rsp_q.status == ST_BLOCKED)

endmodule

// ===== rtl/cst_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
module cst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port; a read of the address being written returns the old word.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/cst_engine.sv =====
// Update logic: applies one request to one table entry.
module cst_engine import cst_pkg::*; #(
	parameter int NUM_SEMAPHORES = NUM_SEMAPHORES_DEF,
	parameter int COUNT_WIDTH    = COUNT_WIDTH_DEF
) (
	input  cst_req_t                     req,
	input  logic [2*COUNT_WIDTH:0]       entry,
	output logic [2*COUNT_WIDTH:0]       entry_new,
	output cst_upd_t                     upd
);

	localparam int CW = COUNT_WIDTH;

	logic          ent_open;
	logic [CW-1:0] ent_ceil;
	logic [CW-1:0] ent_cnt;
	logic [CW-1:0] cnt_inc;
	logic [CW-1:0] cnt_dec;
	logic          in_range;
	logic          val_ok;

	// Entry layout: open flag, ceiling, count.
	assign ent_open = entry[2*CW];
	assign ent_ceil = entry[2*CW-1:CW];
	assign ent_cnt  = entry[CW-1:0];
	assign cnt_inc  = ent_cnt + CW'(1);
	assign cnt_dec  = ent_cnt - CW'(1);

	// Index must address the table, and an open value must be nonzero and fit a count.
	assign in_range = 32'(req.sem_index) < NUM_SEMAPHORES;
	assign val_ok   = (req.initial_value != '0) && ((32'(req.initial_value) >> CW) == 32'd0);

	// Decode the operation against the current entry.
	always_comb begin
		entry_new           = entry;
		upd.wr              = 1'b0;
		upd.rsp.status      = ST_REJECTED;
		upd.rsp.wake        = 1'b0;
		upd.rsp.count_after = '0;
		if (in_range) begin
			unique case (req.operation)
				OP_OPEN: begin
					if (ent_open) begin
						upd.rsp.count_after = VAL_W'(ent_cnt);
					end else if (val_ok) begin
						upd.wr              = 1'b1;
						entry_new           = {1'b1, CW'(req.initial_value),
							CW'(req.initial_value)};
						upd.rsp.status      = ST_DONE;
						upd.rsp.count_after = req.initial_value;
					end
				end
				OP_CLOSE: begin
					if (ent_open) begin
						upd.wr         = 1'b1;
						entry_new      = {1'b0, ent_ceil, CW'(0)};
						upd.rsp.status = ST_DONE;
					end
				end
				OP_UP: begin
					if (ent_open) begin
						if (ent_cnt >= ent_ceil) begin
							upd.rsp.count_after = VAL_W'(ent_cnt);
						end else begin
							upd.wr              = 1'b1;
							entry_new           = {1'b1, ent_ceil, cnt_inc};
							upd.rsp.status      = ST_DONE;
							upd.rsp.wake        = (ent_cnt == '0);
							upd.rsp.count_after = VAL_W'(cnt_inc);
						end
					end
				end
				OP_DOWN: begin
					if (ent_open) begin
						if (ent_cnt == '0) begin
							upd.rsp.status = ST_BLOCKED;
						end else begin
							upd.wr              = 1'b1;
							entry_new           = {1'b1, ent_ceil, cnt_dec};
							upd.rsp.status      = ST_DONE;
							upd.rsp.count_after = VAL_W'(cnt_dec);
						end
					end
				end
			endcase
		end
	end

endmodule

// ===== tb/sv/counting_semaphore_table_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the counting semaphore table with a driver, a monitor and a predictor.
module counting_semaphore_table_test;
	import cst_pkg::*;

	localparam int CLK_HALF     = 4;
	localparam int RESET_CYCLES = 12;
	localparam int RANDOM_ITEMS = 1000;
	localparam int POOL_SIZE    = 8;
	localparam int QUIET_TAIL   = 150;
	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 10;
	localparam int MAX_REPORTS  = 10;

	logic     clk       = 1'b0;
	logic     arst_n    = 1'b0;
	logic     req_valid = 1'b0;
	logic     req_ready;
	cst_req_t req       = '0;
	logic     rsp_valid;
	logic     rsp_ready = 1'b0;
	cst_rsp_t rsp;

	// Shadow of the semaphore table kept by the predictor.
	bit               shadow_open [NUM_SEMAPHORES_DEF];
	logic [VAL_W-1:0] sem_count   [NUM_SEMAPHORES_DEF];
	logic [VAL_W-1:0] sem_ceiling [NUM_SEMAPHORES_DEF];

	cst_req_t pending_requests[$];
	cst_rsp_t expected_results[$];

	int req_gap       = 0;
	int rsp_gap       = 0;
	int req_idle_pct  = 0;
	int rsp_stall_pct = 0;
	int req_accepts   = 0;
	int rsp_accepts   = 0;
	int fail_count    = 0;
	int quiet_cycles  = 0;

	counting_semaphore_table i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always #CLK_HALF clk = ~clk;

	// Applies one request to the shadow table and returns the result it should produce.
	function automatic cst_rsp_t apply_request(cst_req_t r);
		cst_rsp_t         res;
		logic [VAL_W-1:0] cur;
		res = '0;
		res.status = ST_DONE;
		if (r.sem_index >= NUM_SEMAPHORES_DEF) begin
			res.status = ST_REJECTED;
			return res;
		end
		cur = sem_count[r.sem_index];
		if (r.operation == OP_OPEN) begin
			if (shadow_open[r.sem_index]) begin
				res.status      = ST_REJECTED;
				res.count_after = cur;
			end else if (r.initial_value == '0) begin
				res.status = ST_REJECTED;
			end else begin
				shadow_open[r.sem_index] = 1'b1;
				sem_count[r.sem_index]   = r.initial_value;
				sem_ceiling[r.sem_index] = r.initial_value;
				res.count_after          = r.initial_value;
			end
		end else if (!shadow_open[r.sem_index]) begin
			res.status = ST_REJECTED;
		end else begin
			case (r.operation)
				OP_CLOSE: begin
					shadow_open[r.sem_index] = 1'b0;
					sem_count[r.sem_index]   = '0;
				end
				OP_UP: begin
					if (cur >= sem_ceiling[r.sem_index]) begin
						res.status      = ST_REJECTED;
						res.count_after = cur;
					end else begin
						sem_count[r.sem_index] = cur + 1'b1;
						res.wake               = (cur == '0);
						res.count_after        = cur + 1'b1;
					end
				end
				default: begin
					// Down at zero blocks the caller and leaves the count alone.
					if (cur == '0) begin
						res.status = ST_BLOCKED;
					end else begin
						sem_count[r.sem_index] = cur - 1'b1;
						res.count_after        = cur - 1'b1;
					end
				end
			endcase
		end
		return res;
	endfunction

	function automatic int pick_idle_pct();
		case ($urandom_range(0, 3))
			0: return 0;
			1: return 5;
			2: return 20;
			default: return 50;
		endcase
	endfunction

	task automatic add_request(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx,
			logic [VAL_W-1:0] val);
		cst_req_t r;
		r.operation     = op;
		r.sem_index     = idx;
		r.initial_value = val;
		pending_requests.push_back(r);
	endtask

	// Request driver: predicts each accepted transaction and feeds the next one.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req       <= '0;
			req_gap = 0;
		end else begin
			if (req_valid && req_ready) begin
				expected_results.push_back(apply_request(req));
				req_accepts++;
				if (req_accepts % 100 == 0)
					req_idle_pct = pick_idle_pct();
			end
			if (req_valid && !req_ready) begin
				// The current transaction is held until it is taken.
			end else if (req_gap > 0) begin
				req_gap--;
				req_valid <= 1'b0;
			end else if (pending_requests.size() > QUIET_TAIL &&
					$urandom_range(0, 99) < req_idle_pct) begin
				req_gap = $urandom_range(0, 13);
				req_valid <= 1'b0;
			end else if (pending_requests.size() > 0) begin
				req       <= pending_requests.pop_front();
				req_valid <= 1'b1;
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// Result monitor: compares each accepted result with the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
			rsp_gap = 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				rsp_accepts++;
				if (rsp_accepts % 100 == 0)
					rsp_stall_pct = pick_idle_pct();
				if (expected_results.size() == 0) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$display("ERROR: result with none expected: status %0d wake %0d count %0d",
							rsp.status, rsp.wake, rsp.count_after);
				end else begin
					cst_rsp_t want;
					want = expected_results.pop_front();
					if (rsp.status !== want.status || rsp.wake !== want.wake ||
							rsp.count_after !== want.count_after) begin
						fail_count++;
						if (fail_count <= MAX_REPORTS)
							$display("ERROR: result %0d: expected status %0d wake %0d count %0d, got status %0d wake %0d count %0d",
								rsp_accepts, want.status, want.wake, want.count_after,
								rsp.status, rsp.wake, rsp.count_after);
					end
				end
			end
			if (rsp_gap > 0) begin
				rsp_gap--;
				rsp_ready <= 1'b0;
			end else if (pending_requests.size() > QUIET_TAIL &&
					$urandom_range(0, 99) < rsp_stall_pct) begin
				rsp_gap = $urandom_range(0, 13);
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	// Watchdog on cycles in which neither channel moves a transaction.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// Stimulus, reset and end of run.
	initial begin
		logic [IDX_W-1:0] pool[POOL_SIZE];
		logic [IDX_W-1:0] idx;
		logic [VAL_W-1:0] val;
		logic [OP_W-1:0]  op;
		int               pick;

		// Directed part: each operation, the field extremes and the corner cases.
		add_request(OP_OPEN,  8'd0,   16'd0);      // open with zero value
		add_request(OP_OPEN,  8'd0,   16'd1);
		add_request(OP_OPEN,  8'd0,   16'd5);      // open of an open entry
		add_request(OP_UP,    8'd0,   16'hFFFF);   // up at the ceiling
		add_request(OP_DOWN,  8'd0,   16'h0000);
		add_request(OP_DOWN,  8'd0,   16'hFFFF);   // down at zero blocks
		add_request(OP_UP,    8'd0,   16'h0000);   // up from zero wakes
		add_request(OP_CLOSE, 8'd0,   16'h0000);
		add_request(OP_CLOSE, 8'd0,   16'hFFFF);   // close of a closed entry
		add_request(OP_UP,    8'd0,   16'h0000);   // up on a closed entry
		add_request(OP_DOWN,  8'd0,   16'h0000);   // down on a closed entry
		add_request(OP_OPEN,  8'd255, 16'hFFFF);
		add_request(OP_DOWN,  8'd255, 16'h0000);
		add_request(OP_UP,    8'd255, 16'h0000);
		add_request(OP_UP,    8'd255, 16'h0000);   // up at the largest ceiling
		add_request(OP_OPEN,  8'd255, 16'h1234);   // open of an open entry reports count
		add_request(OP_CLOSE, 8'd255, 16'hFFFF);
		add_request(OP_OPEN,  8'hAA,  16'h5555);
		add_request(OP_OPEN,  8'h55,  16'hAAAA);
		add_request(OP_DOWN,  8'hAA,  16'h0000);
		add_request(OP_UP,    8'h55,  16'h0000);
		add_request(OP_CLOSE, 8'hAA,  16'h0000);
		add_request(OP_CLOSE, 8'h55,  16'h0000);

		// Random part: mostly a small pool of entries with small ceilings, so that
		// ceilings, blocking and wakes come often; some requests hit any entry.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 200 == 0)
				foreach (pool[k])
					pool[k] = IDX_W'($urandom_range(0, NUM_SEMAPHORES_DEF - 1));
			if ($urandom_range(0, 9) == 0)
				idx = IDX_W'($urandom_range(0, NUM_SEMAPHORES_DEF - 1));
			else
				idx = pool[$urandom_range(0, POOL_SIZE - 1)];
			pick = $urandom_range(0, 99);
			if (pick < 20)
				op = OP_OPEN;
			else if (pick < 30)
				op = OP_CLOSE;
			else if (pick < 65)
				op = OP_UP;
			else
				op = OP_DOWN;
			pick = $urandom_range(0, 99);
			if (op != OP_OPEN || pick < 15)
				val = VAL_W'($urandom_range(0, 16'hFFFF));
			else if (pick < 25)
				val = '0;
			else if (pick < 30)
				val = '1;
			else
				val = VAL_W'($urandom_range(1, 4));
			add_request(op, idx, val);
		end

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Wait for every request to be taken and every result to come back.
		do
			@(negedge clk);
		while (pending_requests.size() != 0 || req_valid || expected_results.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (fail_count == 0 && expected_results.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
